@@ design/gmig_pkg.sv @@
`default_nettype none

package gmig_pkg;

    localparam int GW          = 10;
    localparam int VW          = 20;
    localparam int MAX_GRID    = 1023;
    localparam int MAX_RESULTS = 7;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int PTR_W       = $clog2(MAX_RESULTS);
    localparam int IN_W        = 8;
    localparam int DATA_W      = 40;
    localparam int USER_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 10;

    localparam logic [1:0] FMT_STRIP  = 2'd0;
    localparam logic [1:0] FMT_QUADS  = 2'd1;
    localparam logic [1:0] FMT_TRIS   = 2'd2;
    localparam logic [1:0] FMT_UNUSED = 2'd3;

    localparam logic KIND_INDEX  = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MESH_FORMAT = 1'b1;

    typedef struct packed {
        logic          kind;
        logic [VW-1:0] value;
        logic [GW-1:0] x;
        logic [GW-1:0] y;
    } rec_t;

    typedef struct packed {
        rec_t [MAX_RESULTS-1:0] entries;
        logic [CNT_W-1:0]       count;
        logic                   done;
    } burst_t;

    function automatic rec_t mk_rec(input logic kind, input logic [VW-1:0] value,
                                    input logic [GW-1:0] x, input logic [GW-1:0] y);
        rec_t r;
        r.kind  = kind;
        r.value = value;
        r.x     = x;
        r.y     = y;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/gmig_step.sv @@
`default_nettype none

module gmig_step
    import gmig_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  item_accept,
    input  wire logic                  restart,
    output burst_t                     burst
);

    logic [GW-1:0] grid_size_reg;
    logic [1:0]    mesh_format_reg;
    logic [GW-1:0] column_reg, column_next;
    logic [GW-1:0] row_reg, row_next;
    logic [VW-1:0] vc_reg, vc_next;
    logic          finished_reg, finished_next;

    logic [GW-1:0] g;
    logic [GW:0]   w;
    logic [GW-1:0] c0, r0, r1, mult_r;
    logic [VW-1:0] vc0;
    logic          fin0;
    logic [2*GW:0] prod;
    logic [VW-1:0] strip_idx, idx_a, idx_b, idx_d, idx_e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg   <= GW'(1);
            mesh_format_reg <= FMT_STRIP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_SIZE:   grid_size_reg   <= cfg_data[GW-1:0];
                REG_MESH_FORMAT: mesh_format_reg <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= '0;
            row_reg      <= GW'(1);
            vc_reg       <= '0;
            finished_reg <= 1'b1;
        end
        else if (item_accept)
        begin
            column_reg   <= column_next;
            row_reg      <= row_next;
            vc_reg       <= vc_next;
            finished_reg <= finished_next;
        end
    end

    // effective grid size, zero taken as one
    always_comb
    begin
        g = grid_size_reg;
        if (grid_size_reg == '0)
            g = GW'(1);
        if (int'(grid_size_reg) > MAX_GRID)
            g = GW'(MAX_GRID);
        w = {1'b0, g} + (GW+1)'(1);
    end

    // restart applies before anything else and sticks even without results
    always_comb
    begin
        c0   = restart ? '0 : column_reg;
        r0   = restart ? ((mesh_format_reg == FMT_STRIP) ? GW'(1) : '0) : row_reg;
        vc0  = restart ? '0 : vc_reg;
        fin0 = restart ? 1'b0 : finished_reg;
        r1   = (mesh_format_reg == FMT_STRIP && r0 == '0) ? GW'(1) : r0;
    end

    // one shared multiply: strip uses (r-3)*w, quads and triangles r*w
    always_comb
    begin
        mult_r    = (mesh_format_reg == FMT_STRIP) ? (r1 - GW'(3)) : r1;
        prod      = (2*GW+1)'(mult_r) * (2*GW+1)'(w);
        strip_idx = VW'((2*GW+2)'(prod) + (2*GW+2)'({w, 1'b0}) + (2*GW+2)'(c0));
        idx_a     = VW'((2*GW+2)'(prod) + (2*GW+2)'(c0));
        idx_b     = idx_a + VW'(1);
        idx_e     = idx_a + VW'(w);
        idx_d     = idx_e + VW'(1);
    end

    always_comb
    begin
        column_next   = c0;
        row_next      = r0;
        vc_next       = vc0;
        finished_next = fin0;
        burst         = '0;
        if (!fin0)
        begin
            if (mesh_format_reg == FMT_UNUSED)
            begin
                finished_next = 1'b1;
            end
            else
            begin
                row_next = r1;
                if (r1 > g)
                begin
                    finished_next = 1'b1;
                end
                else
                begin
                    if (c0 <= g)
                    begin
                        burst.done = (c0 == g) && (r1 == g);
                        if (mesh_format_reg == FMT_STRIP)
                        begin
                            burst.entries[0] = mk_rec(KIND_INDEX, vc0, '0, '0);
                            burst.entries[1] = mk_rec(KIND_VERTEX, vc0, c0, r1);
                            if (r1 == GW'(1))
                            begin
                                burst.entries[2] = mk_rec(KIND_INDEX, vc0 + VW'(1), '0, '0);
                                burst.entries[3] = mk_rec(KIND_VERTEX, vc0 + VW'(1), c0, '0);
                                burst.count      = CNT_W'(4);
                                vc_next          = vc0 + VW'(2);
                            end
                            else
                            begin
                                if (r1 == GW'(2))
                                    burst.entries[2] = mk_rec(KIND_INDEX,
                                                              VW'({c0, 1'b0}), '0, '0);
                                else
                                    burst.entries[2] = mk_rec(KIND_INDEX, strip_idx, '0, '0);
                                burst.count = CNT_W'(3);
                                vc_next     = vc0 + VW'(1);
                            end
                        end
                        else
                        begin
                            burst.entries[0] = mk_rec(KIND_VERTEX, vc0, c0, r1);
                            burst.count      = CNT_W'(1);
                            vc_next          = vc0 + VW'(1);
                            if (c0 < g && r1 < g)
                            begin
                                burst.entries[1] = mk_rec(KIND_INDEX, idx_a, '0, '0);
                                burst.entries[2] = mk_rec(KIND_INDEX, idx_b, '0, '0);
                                burst.entries[3] = mk_rec(KIND_INDEX, idx_d, '0, '0);
                                if (mesh_format_reg == FMT_TRIS)
                                begin
                                    burst.entries[4] = mk_rec(KIND_INDEX, idx_d, '0, '0);
                                    burst.entries[5] = mk_rec(KIND_INDEX, idx_e, '0, '0);
                                    burst.entries[6] = mk_rec(KIND_INDEX, idx_a, '0, '0);
                                    burst.count      = CNT_W'(7);
                                end
                                else
                                begin
                                    burst.entries[4] = mk_rec(KIND_INDEX, idx_e, '0, '0);
                                    burst.count      = CNT_W'(5);
                                end
                            end
                        end
                    end
                    // move on: next column, next row, or finish
                    if (c0 < g)
                    begin
                        column_next = c0 + GW'(1);
                    end
                    else if (r1 >= g)
                    begin
                        finished_next = 1'b1;
                    end
                    else
                    begin
                        row_next    = r1 + GW'(1);
                        column_next = '0;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ design/gmig_emit.sv @@
`default_nettype none

module gmig_emit
    import gmig_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire burst_t             burst,
    output logic                    ready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [DATA_W-1:0]       m_tdata,
    output logic [USER_W-1:0]       m_tuser,
    output logic                    m_tlast
);

    rec_t [MAX_RESULTS-1:0] entries_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [PTR_W-1:0]       ptr_reg;
    logic                   at_last;
    rec_t                   cur;

    assign m_tvalid = (cnt_reg != '0);
    assign at_last  = (CNT_W'(ptr_reg) == cnt_reg - CNT_W'(1));
    assign ready    = !m_tvalid || (m_tready && at_last);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entries_reg <= burst.entries;
            done_reg    <= burst.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ptr_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= burst.count;
            ptr_reg <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (at_last)
                cnt_reg <= '0;
            else
                ptr_reg <= ptr_reg + PTR_W'(1);
        end
    end

    assign cur     = entries_reg[ptr_reg];
    assign m_tdata = {cur.y, cur.x, cur.value};
    assign m_tuser = {done_reg, cur.kind};
    assign m_tlast = at_last;

endmodule

`default_nettype wire

@@ design/grid_mesh_index_generator.sv @@
// Mesh index generator over a square grid of (grid_size+1)^2 points. Each input
// transaction advances the walk by one grid point (restart=1 begins a new mesh)
// and produces a burst of results: 3 or 4 in strip mode, 1 or 5 in quad mode,
// 1 or 7 in triangle mode, none once the mesh is finished. A point's burst is
// computed in the cycle its transaction is taken and then leaves the single
// result port one transaction per cycle while m_tready is high; the next input
// transaction is taken in the cycle the final result of the current burst goes
// out. Configuration is to be written through cfg_we/cfg_index/cfg_data while
// no burst is pending; the block does not enforce this.
`default_nettype none

module grid_mesh_index_generator
    import gmig_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_W-1:0]       s_tdata,   // [0] restart, [7:1] zero
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [DATA_W-1:0]          m_tdata,   // [19:0] index_value, [29:20] grid_x,
                                                  // [39:30] grid_y
    output logic [USER_W-1:0]          m_tuser,   // [0] kind, [1] mesh_done
    output logic                       m_tlast    // last_of_run
);

    logic   item_accept;
    burst_t burst;

    assign item_accept = s_tvalid && s_tready;

    gmig_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_accept (item_accept),
        .restart     (s_tdata[0]),
        .burst       (burst)
    );

    gmig_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (item_accept),
        .burst    (burst),
        .ready    (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ design/gmig_checker.sv @@
`default_nettype none

module gmig_checker
    import gmig_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [DATA_W-1:0] m_tdata,
    input wire logic [USER_W-1:0] m_tuser,
    input wire logic              m_tlast
);

    // stalled result holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("result changed while stalled");

    // empty result side never blocks the input
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with no pending result");

    // a burst runs on without gaps until its last transaction
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("burst broken before last result");

    // no new point is taken in the middle of a burst
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken while burst pending");

endmodule

bind grid_mesh_index_generator gmig_checker u_gmig_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
